FILE: design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    OP_DUMP      = 3'd0,
    OP_PUSH_FRNT = 3'd1,
    OP_PUSH_BACK = 3'd2,
    OP_POP_FRNT  = 3'd3,
    OP_POP_BACK  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cell move command
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_LEFT  = 2'd1,
    CMD_RIGHT = 2'd2,
    CMD_LOAD  = 2'd3
  } cell_cmd_t;

endpackage

FILE: design/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the queue chain; holds, or takes its neighbour or a new value.
// ----------------------------------------------------------------------------
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  input  logic signed [DATA_W-1:0] load,
  output logic signed [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] value_next;

  always_comb begin
    case (cmd)
      CMD_HOLD:  value_next = value;
      CMD_LEFT:  value_next = left;
      CMD_RIGHT: value_next = right;
      CMD_LOAD:  value_next = load;
      default:   value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: design/bounded_deque_with_dump_top.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_dump_top
// Bounded double-ended queue held in a chain of cells, front always in cell 0.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | op, item_value
//   out     | output    | out_valid / out_stall | out_value, status, last
//
// push and pop each give one transfer
// a dump gives one transfer per stored value, one per cycle while the output
// is not stalled, by rotating the cell chain towards cell 0 (an empty queue
// gives one EMPTY transfer); the input stays stalled until the dump is done
// reset clears the fill count and control; cell contents are not reset
// a stalled output holds its transfer and stalls the input
// ----------------------------------------------------------------------------
module bounded_deque_with_dump_top
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               op,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic [1:0]               status,
  output logic                     last
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            dump_left;
  logic                     out_free;
  logic                     in_acc;
  logic                     dump_step;
  logic                     is_full;
  logic                     is_empty;
  cell_cmd_t                cmd [DEPTH];
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] load_data;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign dump_step = (state == S_DUMP) && out_free;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign load_data = dump_step ? cell_q[0] : item_value;

  // cell commands and next fill count
  always_comb begin
    count_next = count;
    for (int i = 0; i < DEPTH; i++) begin
      cmd[i] = CMD_HOLD;
    end
    if (dump_step) begin
      for (int i = 0; i < DEPTH; i++) begin
        cmd[i] = (CW'(i + 1) == count) ? CMD_LOAD : CMD_RIGHT;
      end
    end else if (in_acc) begin
      case (op)
        OP_PUSH_FRNT: begin
          if (!is_full) begin
            for (int i = 0; i < DEPTH; i++) begin
              cmd[i] = (i == 0) ? CMD_LOAD : CMD_LEFT;
            end
            count_next = count + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (!is_full) begin
            for (int i = 0; i < DEPTH; i++) begin
              cmd[i] = (CW'(i) == count) ? CMD_LOAD : CMD_HOLD;
            end
            count_next = count + 1'b1;
          end
        end
        OP_POP_FRNT: begin
          if (!is_empty) begin
            for (int i = 0; i < DEPTH; i++) begin
              cmd[i] = CMD_RIGHT;
            end
            count_next = count - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!is_empty) begin
            count_next = count - 1'b1;
          end
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = item_value;
    end else begin : g_mid_l
      assign left_in = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_q[g+1];
    end
    bdq_cell u_cell (
      .clk   (clk),
      .cmd   (cmd[g]),
      .left  (left_in),
      .right (right_in),
      .load  (load_data),
      .value (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_left <= '0;
      out_valid <= 1'b0;
      out_value <= '0;
      status    <= ST_OK;
      last      <= 1'b0;
    end else begin
      count <= count_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_DUMP: begin
                if (is_empty) begin
                  out_valid <= 1'b1;
                  out_value <= '0;
                  status    <= ST_EMPTY;
                  last      <= 1'b1;
                end else begin
                  state     <= S_DUMP;
                  dump_left <= count;
                end
              end
              OP_PUSH_FRNT, OP_PUSH_BACK: begin
                out_valid <= 1'b1;
                out_value <= '0;
                status    <= is_full ? ST_FULL : ST_OK;
                last      <= 1'b1;
              end
              OP_POP_FRNT, OP_POP_BACK: begin
                out_valid <= 1'b1;
                out_value <= '0;
                status    <= is_empty ? ST_EMPTY : ST_OK;
                last      <= 1'b1;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DUMP: begin
          if (dump_step) begin
            out_valid <= 1'b1;
            out_value <= cell_q[0];
            status    <= ST_OK;
            last      <= (dump_left == CW'(1));
            dump_left <= dump_left - 1'b1;
            if (dump_left == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_dump_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (dump_left != '0) && (dump_left <= count))
    else $error("dump counter out of range");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_full && (op == OP_PUSH_FRNT || op == OP_PUSH_BACK))
      |=> $stable(count))
    else $error("refused push changed fill count");

  a_no_input_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> in_stall)
    else $error("input taken during dump");

endmodule
